// ===== src/sb5_pkg.sv =====
// Shared constants and types of the 5x5 Sobel gradient stream.
// No dependencies; every other file of the block but sb5_ram imports this package.
package sb5_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 5;

  // Counter and geometry widths.
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);
  localparam int EFF_H_W = $clog2(MAX_HEIGHT + 1);

  // Configuration port.
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [IMG_W_W-1:0]   IMG_W_RESET = 12'd640;
  localparam logic [IMG_H_W-1:0]   IMG_H_RESET = 13'd480;

  // Pixel and gray conversion.
  localparam int CHAN_W    = 8;
  localparam int GRAY_W    = 16;
  localparam int GSUM_W    = 24;
  localparam int GRAY_KR   = 19595;
  localparam int GRAY_KG   = 38470;
  localparam int GRAY_KB   = 7471;
  localparam int GRAY_BIAS = 128;

  // Line stores: one RAM per buffered row.
  localparam int LINES = 4;
  localparam int SLOT_W = $clog2(LINES);
  localparam int TAPS  = 5;

  // Column sums and kernel sums.
  localparam int S_W   = 20;  // smoothing column sum, unsigned
  localparam int D_W   = 19;  // derivative column sum, signed
  localparam int SUM_W = 24;  // full kernel sum, signed

  // Division by 48 with rounding: (mag + 24) >> 4, then times 1/3 by reciprocal.
  localparam int DIV_BIAS    = 24;
  localparam int DIV_SHIFT   = 4;
  localparam int T_W         = 18;
  localparam int RECIP       = 174763;
  localparam int RECIP_SHIFT = 19;

  // Result fields.
  localparam int GRAD_W = 17;
  localparam int CROW_W = 12;
  localparam int CCOL_W = 11;

  // One column of the window, reduced to its two weighted sums.
  typedef struct packed {
    logic [S_W-1:0] smooth;
    logic [D_W-1:0] deriv;   // two's complement
  } col_t;

  // Position data that travels with a pixel down the pipeline.
  typedef struct packed {
    logic [CROW_W-1:0] crow;
    logic [CCOL_W-1:0] ccol;
    logic              last;
  } meta_t;

endpackage

// ===== src/sb5_if.sv =====
// Stream interfaces of the 5x5 Sobel gradient block: RGB pixels in, gradients out.
// Depends on sb5_pkg for field widths.
interface sb5_pix_if import sb5_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface sb5_grad_if import sb5_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [CROW_W-1:0]        center_row;
  logic [CCOL_W-1:0]        center_col;
  logic                     frame_last;

  modport source (output valid, grad_x, grad_y, center_row, center_col, frame_last,
                  input ready);
  modport sink   (input valid, grad_x, grad_y, center_row, center_col, frame_last,
                  output ready);
endinterface

// ===== src/sobel5_gradient_stream.sv =====
// Top level of the 5x5 Sobel gradient stream.
// Depends on sb5_pkg, sb5_if, sb5_ram, sb5_cell and sb5_div48.
//
// Usage:
//   in_pix carries RGB pixels in raster order; frame_start on a pixel puts it at
//   row 0, column 0. out_grad carries one gradient pair per interior centre pixel
//   (two-pixel border excluded), with the centre's row and column, and frame_last
//   on the last one of the frame. A transfer happens when valid and ready are high.
//   cfg_we writes image_width (index 0) or image_height (index 1) from cfg_wdata;
//   write only while no pixel is in flight.
// Throughput: one pixel per cycle while out_grad does not stall. Each pixel makes one read from each of the four
//   line-store RAMs and one write into one of them, and shifts the five-cell
//   window chain by one column.
// Path: the pixel that completes a window passes the stage B registers, the window cells,
//   the kernel-sum registers, the two divider stages and the output register to out_grad.
// Reset: row and column counters clear, width and height return to 640 and 480,
//   the window cells clear. The line stores are not cleared.
// Stall: the pipeline holds while the output register is full and out_grad.ready
//   is low; in_pix.ready falls in that same cycle and nothing is lost.
module sobel5_gradient_stream import sb5_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sb5_pix_if.sink               in_pix,
  sb5_grad_if.source            out_grad,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------- control
  logic adv;
  logic accept;
  logic out_valid_r, out_valid_nxt;

  assign adv          = !out_valid_r || out_grad.ready;
  assign in_pix.ready = adv && rst_n;
  assign accept       = in_pix.valid && in_pix.ready;

  // ---------------------------------------------------------------- configuration
  logic [IMG_W_W-1:0] image_width_r;
  logic [IMG_H_W-1:0] image_height_r;
  logic [EFF_W_W-1:0] eff_w;
  logic [EFF_H_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMG_W_RESET;
      image_height_r <= IMG_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    if (image_width_r < IMG_W_W'(MIN_DIM)) begin
      eff_w = EFF_W_W'(MIN_DIM);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      eff_w = EFF_W_W'(MAX_WIDTH);
    end else begin
      eff_w = EFF_W_W'(image_width_r);
    end
    if (image_height_r < IMG_H_W'(MIN_DIM)) begin
      eff_h = EFF_H_W'(MIN_DIM);
    end else if (int'(image_height_r) > MAX_HEIGHT) begin
      eff_h = EFF_H_W'(MAX_HEIGHT);
    end else begin
      eff_h = EFF_H_W'(image_height_r);
    end
  end

  // ---------------------------------------------------------------- stage A: position and gray
  logic [COL_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]   cur_c;
  logic [ROW_W-1:0]   cur_r;
  logic [EFF_W_W-1:0] c_ext, c_inc;
  logic [EFF_H_W-1:0] r_ext, r_inc;
  logic               emit_a;
  meta_t              meta_a;
  logic [GSUM_W-1:0]  gsum;
  logic [GRAY_W-1:0]  gray_a;

  always_comb begin
    cur_c = in_pix.frame_start ? '0 : col_cnt_r;
    cur_r = in_pix.frame_start ? '0 : row_cnt_r;
    c_ext = EFF_W_W'(cur_c);
    r_ext = EFF_H_W'(cur_r);
    c_inc = c_ext + EFF_W_W'(1);
    r_inc = r_ext + EFF_H_W'(1);

    emit_a = (cur_r >= ROW_W'(4)) && (cur_c >= COL_W'(4)) && (r_ext < eff_h) && (c_ext < eff_w);
    meta_a.crow = CROW_W'(cur_r - ROW_W'(2));
    meta_a.ccol = CCOL_W'(cur_c - COL_W'(2));
    meta_a.last = (r_ext == eff_h - EFF_H_W'(1)) && (c_ext == eff_w - EFF_W_W'(1));

    // Wrap at the end of a row and of a frame.
    if (c_inc >= eff_w) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= eff_h) ? '0 : ROW_W'(r_inc);
    end else begin
      col_cnt_nxt = COL_W'(c_inc);
      row_cnt_nxt = cur_r;
    end

    gsum = GSUM_W'(in_pix.red) * GSUM_W'(GRAY_KR)
         + GSUM_W'(in_pix.green) * GSUM_W'(GRAY_KG)
         + GSUM_W'(in_pix.blue) * GSUM_W'(GRAY_KB)
         + GSUM_W'(GRAY_BIAS);
    gray_a = gsum[GSUM_W-1 -: GRAY_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Line stores: every RAM is read at the column, the row's own slot is written.
  logic [LINES-1:0]  ram_we;
  logic [GRAY_W-1:0] ram_rd [LINES];

  for (genvar k = 0; k < LINES; k++) begin : g_line
    assign ram_we[k] = accept && (cur_r[SLOT_W-1:0] == SLOT_W'(k));
    sb5_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (cur_c),
      .wdata (gray_a),
      .re    (accept),
      .raddr (cur_c),
      .rdata (ram_rd[k])
    );
  end

  // Stage A to B registers.
  logic              v_b_r;
  logic              emit_b_r;
  logic [GRAY_W-1:0] gray_b_r;
  logic [SLOT_W-1:0] slot_b_r;
  meta_t             meta_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (adv) begin
      v_b_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      emit_b_r <= emit_a;
      gray_b_r <= gray_a;
      slot_b_r <= cur_r[SLOT_W-1:0];
      meta_b_r <= meta_a;
    end
  end

  // ---------------------------------------------------------------- stage B: column sums
  logic [GRAY_W-1:0] pix [TAPS];
  logic [S_W-1:0]    col_s;
  logic signed [D_W-1:0] col_d;
  col_t              col_new;

  // Oldest row first; the newest row is the pixel itself.
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      pix[i] = ram_rd[SLOT_W'(slot_b_r + SLOT_W'(i))];
    end
    pix[TAPS-1] = gray_b_r;

    col_s = S_W'(pix[0]) + (S_W'(pix[1]) << 2) + (S_W'(pix[2]) << 2) + (S_W'(pix[2]) << 1)
          + (S_W'(pix[3]) << 2) + S_W'(pix[4]);
    col_d = ($signed(D_W'(pix[3])) <<< 1) + $signed(D_W'(pix[4]))
          - $signed(D_W'(pix[0])) - ($signed(D_W'(pix[1])) <<< 1);

    col_new.smooth = col_s;
    col_new.deriv  = col_d;
  end

  // Window chain: cell 0 holds the oldest column, the last cell the newest.
  col_t cell_in  [TAPS];
  col_t cell_out [TAPS];
  logic shift;

  assign shift = adv && v_b_r;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    if (j == TAPS - 1) begin : g_head
      assign cell_in[j] = col_new;
    end else begin : g_body
      assign cell_in[j] = cell_out[j+1];
    end
    sb5_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .col_in  (cell_in[j]),
      .col_out (cell_out[j])
    );
  end

  // Stage B to W registers.
  logic  v_w_r;
  meta_t meta_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_w_r <= 1'b0;
    end else if (adv) begin
      v_w_r <= v_b_r && emit_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_w_r <= meta_b_r;
    end
  end

  // ---------------------------------------------------------------- stage W: kernel sums
  logic signed [SUM_W-1:0] s_ext [TAPS];
  logic signed [SUM_W-1:0] d_ext [TAPS];
  logic signed [SUM_W-1:0] sx_nxt, sy_nxt;

  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      s_ext[j] = $signed(SUM_W'(cell_out[j].smooth));
      d_ext[j] = SUM_W'($signed(cell_out[j].deriv));
    end
    // X applies the derivative weights across columns, Y the smoothing weights.
    sx_nxt = s_ext[4] + (s_ext[3] <<< 1) - (s_ext[1] <<< 1) - s_ext[0];
    sy_nxt = d_ext[0] + (d_ext[1] <<< 2) + (d_ext[2] <<< 2) + (d_ext[2] <<< 1)
           + (d_ext[3] <<< 2) + d_ext[4];
  end

  logic                    v_s_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  meta_t                   meta_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s_r <= 1'b0;
    end else if (adv) begin
      v_s_r <= v_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      meta_s_r <= meta_w_r;
    end
  end

  // ---------------------------------------------------------------- divide by 48
  logic signed [GRAD_W-1:0] qx, qy;

  sb5_div48 u_div_x (.clk(clk), .adv(adv), .sum(sx_r), .quo(qx));
  sb5_div48 u_div_y (.clk(clk), .adv(adv), .sum(sy_r), .quo(qy));

  // Position data follows the two divider stages.
  logic  v_d_r, v_m_r;
  meta_t meta_d_r, meta_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
      v_m_r <= 1'b0;
    end else if (adv) begin
      v_d_r <= v_s_r;
      v_m_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_d_r <= meta_s_r;
      meta_m_r <= meta_d_r;
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [GRAD_W-1:0] grad_x_r, grad_y_r;
  meta_t                    meta_o_r;

  assign out_valid_nxt = adv ? v_m_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_x_r <= qx;
      grad_y_r <= qy;
      meta_o_r <= meta_m_r;
    end
  end

  assign out_grad.valid      = out_valid_r;
  assign out_grad.grad_x     = grad_x_r;
  assign out_grad.grad_y     = grad_y_r;
  assign out_grad.center_row = meta_o_r.crow;
  assign out_grad.center_col = meta_o_r.ccol;
  assign out_grad.frame_last = meta_o_r.last;

  // ---------------------------------------------------------------- assertions
  // Each transfer writes exactly one line store, and no write happens without one.
  a_one_line_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ram_we) && (accept == (ram_we != '0)))
    else $error("line store write does not match the input transfer");

  // The column counter stays inside the row after a transfer with fixed geometry.
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(accept) && !$past(cfg_we)) |-> (EFF_W_W'(col_cnt_r) < eff_w))
    else $error("column counter ran past the row width");

  // The row counter stays inside the frame after a transfer with fixed geometry.
  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(accept) && !$past(cfg_we)) |-> (EFF_H_W'(row_cnt_r) < eff_h))
    else $error("row counter ran past the frame height");

  // Results never belong to a centre in the top two rows or the left two columns.
  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((meta_o_r.crow >= CROW_W'(2)) && (meta_o_r.ccol >= CCOL_W'(2))))
    else $error("result emitted for a border centre");

endmodule

// ===== src/sb5_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module sb5_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sb5_cell.sv =====
// One column cell of the sliding 5x5 window; holds the column's weighted sums.
// Depends on sb5_pkg for col_t.
module sb5_cell import sb5_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic shift,
  input  col_t col_in,
  output col_t col_out
);

  col_t col_r;
  col_t col_nxt;

  // Take the neighbor's column whenever a pixel moves the window.
  always_comb begin
    col_nxt = shift ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// ===== src/sb5_div48.sv =====
// Two-stage signed divide by 48, rounding half away from zero.
// Depends on sb5_pkg for widths and the reciprocal constant.
module sb5_div48 import sb5_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [SUM_W-1:0]  sum,
  output logic signed [GRAD_W-1:0] quo
);

  localparam logic [T_W-1:0] RECIP_C = T_W'(RECIP);

  logic [SUM_W-1:0]   mag;
  logic [T_W-1:0]     t_r, t_nxt;
  logic               neg_r, neg2_r;
  logic [2*T_W-1:0]   prod_r, prod_nxt;
  logic [GRAD_W-1:0]  qmag;

  // Stage one: magnitude, rounding bias and the divide by 16.
  always_comb begin
    mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    t_nxt = T_W'((mag + SUM_W'(DIV_BIAS)) >> DIV_SHIFT);
  end

  // Stage two: divide by 3 through the reciprocal.
  always_comb begin
    prod_nxt = t_r * RECIP_C;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r    <= t_nxt;
      neg_r  <= sum[SUM_W-1];
      prod_r <= prod_nxt;
      neg2_r <= neg_r;
    end
  end

  // Restore the sign.
  always_comb begin
    qmag = prod_r[RECIP_SHIFT +: GRAD_W];
    quo  = neg2_r ? -$signed(qmag) : $signed(qmag);
  end

endmodule
